@@ rtl/vtcc_pkg.sv @@
// shared types and constants for the vertex transform and clip outcode block
`default_nettype none

package vtcc_pkg;

   // field widths
   localparam int COORD_W    = 32;
   localparam int ENTRY_W    = 16;
   localparam int ROW_W      = 64;
   localparam int NUM_ROWS   = 4;
   localparam int NUM_LANES  = 4;
   localparam int PROD_W     = COORD_W + ENTRY_W;
   localparam int SUM_W      = PROD_W + 2;
   localparam int OUTCODE_W  = 6;
   localparam int CSR_IDX_W  = 3;

   // rounding: Q20.28 to Q16.16, half toward +infinity
   localparam int FRAC_SHIFT = 12;
   localparam int ROUND_BIAS = 2 ** (FRAC_SHIFT - 1);

   // identity matrix at reset
   localparam logic [ROW_W-1:0] ROW_RESET [NUM_ROWS] = '{
      64'h0000_0000_0000_1000,
      64'h0000_0000_1000_0000,
      64'h0000_1000_0000_0000,
      64'h1000_0000_0000_0000
   };

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROW0 = 3'd0,
      CSR_ROW1 = 3'd1,
      CSR_ROW2 = 3'd2,
      CSR_ROW3 = 3'd3
   } csr_index_type;

   // outcode bit positions
   localparam int OC_Z_NEAR   = 0;
   localparam int OC_Z_FAR    = 1;
   localparam int OC_X_LEFT   = 2;
   localparam int OC_X_RIGHT  = 3;
   localparam int OC_Y_BOTTOM = 4;
   localparam int OC_Y_TOP    = 5;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [ENTRY_W-1:0] entry_type;
   typedef coord_type [NUM_ROWS-1:0]  vertex_type;
   typedef entry_type [NUM_ROWS-1:0]  column_type;

   // what one lane hands to the merge stage
   typedef struct packed {
      logic      sat;
      coord_type value;
   } lane_result_type;

   typedef lane_result_type [NUM_LANES-1:0] lane_bundle_type;

endpackage

`default_nettype wire

@@ rtl/vtcc_lane.sv @@
// one output column: four products, adder tree, rounding and saturation
`default_nettype none

module vtcc_lane (
   input  wire logic                      clock,
   input  wire vtcc_pkg::vertex_type      vertex_i,
   input  wire vtcc_pkg::column_type      column_i,
   output vtcc_pkg::lane_result_type      result_o
);
   import vtcc_pkg::*;

   logic signed [PROD_W-1:0] prod_in  [NUM_ROWS];
   logic signed [PROD_W-1:0] prod_ff  [NUM_ROWS];
   logic signed [SUM_W-1:0]  pair_in  [2];
   logic signed [SUM_W-1:0]  pair_ff  [2];
   logic signed [SUM_W-1:0]  total;
   logic signed [SUM_W-1:0]  shifted;
   logic                     ovf;
   lane_result_type          res_in;
   lane_result_type          res_ff;

   // stage 1: one 32x16 product per row
   always_comb begin
      for (int i = 0; i < NUM_ROWS; i++) begin
         prod_in[i] = $signed(vertex_i[i]) * $signed(column_i[i]);
      end
   end

   // stage 2: pairwise sums, rounding bias folded into the first pair
   always_comb begin
      pair_in[0] = SUM_W'(prod_ff[0]) + SUM_W'(prod_ff[1]) + SUM_W'(ROUND_BIAS);
      pair_in[1] = SUM_W'(prod_ff[2]) + SUM_W'(prod_ff[3]);
   end

   // stage 3: final sum, floor shift and clamp to 32 bits
   always_comb begin
      total   = pair_ff[0] + pair_ff[1];
      shifted = total >>> FRAC_SHIFT;
      ovf     = !((&shifted[SUM_W-1:COORD_W-1]) || !(|shifted[SUM_W-1:COORD_W-1]));
      res_in.sat = ovf;
      if (ovf) begin
         res_in.value = shifted[SUM_W-1] ? {1'b1, {(COORD_W-1){1'b0}}}
                                         : {1'b0, {(COORD_W-1){1'b1}}};
      end else begin
         res_in.value = shifted[COORD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      pair_ff <= pair_in;
      res_ff  <= res_in;
   end

   assign result_o = res_ff;

endmodule

`default_nettype wire

@@ rtl/vtcc_merge.sv @@
// merge stage: clip tests across lanes, saturation flag, output registers
`default_nettype none

module vtcc_merge (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       valid_i,
   input  wire vtcc_pkg::lane_bundle_type  lanes_i,
   output logic                            rsp_strobe,
   output vtcc_pkg::coord_type             rsp_clip_x,
   output vtcc_pkg::coord_type             rsp_clip_y,
   output vtcc_pkg::coord_type             rsp_clip_z,
   output vtcc_pkg::coord_type             rsp_clip_w,
   output logic [vtcc_pkg::OUTCODE_W-1:0]  rsp_outcode,
   output logic                            rsp_saturated
);
   import vtcc_pkg::*;

   logic signed [COORD_W:0]  cx, cy, cz, cw, neg_w;
   logic [OUTCODE_W-1:0]     code_in;
   logic                     sat_in;
   logic                     strobe_ff;
   coord_type                x_ff, y_ff, z_ff, w_ff;
   logic [OUTCODE_W-1:0]     code_ff;
   logic                     sat_ff;

   // compare at one extra bit so that -w is exact
   always_comb begin
      cx    = {lanes_i[0].value[COORD_W-1], lanes_i[0].value};
      cy    = {lanes_i[1].value[COORD_W-1], lanes_i[1].value};
      cz    = {lanes_i[2].value[COORD_W-1], lanes_i[2].value};
      cw    = {lanes_i[3].value[COORD_W-1], lanes_i[3].value};
      neg_w = -cw;
      code_in              = '0;
      code_in[OC_Z_NEAR]   = cz < 0;
      code_in[OC_Z_FAR]    = cz > cw;
      code_in[OC_X_LEFT]   = cx < neg_w;
      code_in[OC_X_RIGHT]  = cx > cw;
      code_in[OC_Y_BOTTOM] = cy < neg_w;
      code_in[OC_Y_TOP]    = cy > cw;
      sat_in = 1'b0;
      for (int j = 0; j < NUM_LANES; j++) begin
         sat_in = sat_in | lanes_i[j].sat;
      end
   end

   // strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= valid_i;
      end
   end

   // result word
   always_ff @(posedge clock) begin
      x_ff    <= lanes_i[0].value;
      y_ff    <= lanes_i[1].value;
      z_ff    <= lanes_i[2].value;
      w_ff    <= lanes_i[3].value;
      code_ff <= code_in;
      sat_ff  <= sat_in;
   end

   assign rsp_strobe    = strobe_ff;
   assign rsp_clip_x    = x_ff;
   assign rsp_clip_y    = y_ff;
   assign rsp_clip_z    = z_ff;
   assign rsp_clip_w    = w_ff;
   assign rsp_outcode   = code_ff;
   assign rsp_saturated = sat_ff;

`ifndef SYNTHESIS
   // both depth planes failed only when w is negative
   a_z_both_neg_w: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_outcode[OC_Z_NEAR] && rsp_outcode[OC_Z_FAR] |-> rsp_clip_w[COORD_W-1])
      else $error("z outside both planes with non-negative w");

   a_x_both_neg_w: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_outcode[OC_X_LEFT] && rsp_outcode[OC_X_RIGHT] |-> rsp_clip_w[COORD_W-1])
      else $error("x outside both planes with non-negative w");

   a_y_both_neg_w: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_outcode[OC_Y_BOTTOM] && rsp_outcode[OC_Y_TOP] |-> rsp_clip_w[COORD_W-1])
      else $error("y outside both planes with non-negative w");
`endif

endmodule

`default_nettype wire

@@ rtl/vertex_transform_clip_code_top.sv @@
// top level: matrix registers, four column lanes and the merge stage
`default_nettype none

// Vertex transform and clip outcode. Each accepted vertex (Q16.16 x, y, z, w)
// is multiplied as a row vector by the 4x4 Q4.12 matrix in the four row
// registers; the four output columns are computed by four lanes in parallel,
// each a three-stage pipeline of multipliers, adder tree and round/clamp, and
// a merge stage forms the six-bit outcode and the saturation flag. busy never
// rises: a new vertex may be started in every cycle, and its word sits on the
// rsp_ ports with rsp_strobe once it has passed the lane product, pair-sum and
// result registers and the merge output register. It is held for one
// cycle only, since the receiver cannot stall the block. Rows reset to the
// identity matrix; write them only while no vertex is in flight.
// Writes to indexes beyond the four rows are ignored.
module vertex_transform_clip_code_top (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire vtcc_pkg::coord_type                 req_in_x,
   input  wire vtcc_pkg::coord_type                 req_in_y,
   input  wire vtcc_pkg::coord_type                 req_in_z,
   input  wire vtcc_pkg::coord_type                 req_in_w,
   input  wire logic                                csr_write_en,
   input  wire logic [vtcc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [vtcc_pkg::ROW_W-1:0]          csr_wdata,
   output logic                                     rsp_strobe,
   output vtcc_pkg::coord_type                      rsp_clip_x,
   output vtcc_pkg::coord_type                      rsp_clip_y,
   output vtcc_pkg::coord_type                      rsp_clip_z,
   output vtcc_pkg::coord_type                      rsp_clip_w,
   output logic [vtcc_pkg::OUTCODE_W-1:0]           rsp_outcode,
   output logic                                     rsp_saturated
);
   import vtcc_pkg::*;

   localparam int LANE_DEPTH = 3;

   logic [ROW_W-1:0]      row_in [NUM_ROWS];
   logic [ROW_W-1:0]      row_ff [NUM_ROWS];
   logic [LANE_DEPTH-1:0] valid_in;
   logic [LANE_DEPTH-1:0] valid_ff;
   logic                  accept;
   vertex_type            vertex;
   lane_bundle_type       lanes;

   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign vertex = {req_in_w, req_in_z, req_in_y, req_in_x};

   // matrix row registers
   always_comb begin
      row_in = row_ff;
      if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            CSR_ROW0: row_in[0] = csr_wdata;
            CSR_ROW1: row_in[1] = csr_wdata;
            CSR_ROW2: row_in[2] = csr_wdata;
            CSR_ROW3: row_in[3] = csr_wdata;
            default:  row_in    = row_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= ROW_RESET;
      end else begin
         row_ff <= row_in;
      end
   end

   // valid tracking through the lane pipeline
   always_comb begin
      valid_in = {valid_ff[LANE_DEPTH-2:0], accept};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // one lane per output column; lane j takes entry j of every row
   for (genvar j = 0; j < NUM_LANES; j++) begin : g_lane
      column_type column;

      always_comb begin
         for (int i = 0; i < NUM_ROWS; i++) begin
            column[i] = row_ff[i][ENTRY_W*j +: ENTRY_W];
         end
      end

      vtcc_lane u_lane (
         .clock    (clock),
         .vertex_i (vertex),
         .column_i (column),
         .result_o (lanes[j])
      );
   end

   vtcc_merge u_merge (
      .clock         (clock),
      .reset         (reset),
      .valid_i       (valid_ff[LANE_DEPTH-1]),
      .lanes_i       (lanes),
      .rsp_strobe    (rsp_strobe),
      .rsp_clip_x    (rsp_clip_x),
      .rsp_clip_y    (rsp_clip_y),
      .rsp_clip_z    (rsp_clip_z),
      .rsp_clip_w    (rsp_clip_w),
      .rsp_outcode   (rsp_outcode),
      .rsp_saturated (rsp_saturated)
   );

`ifndef SYNTHESIS
   a_start_to_word: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##(LANE_DEPTH + 1) rsp_strobe)
      else $error("started vertex produced no word");

   a_word_has_start: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept, LANE_DEPTH + 1))
      else $error("word without a started vertex");

   a_row0_write: assert property (@(posedge clock) disable iff (reset)
      csr_write_en && (csr_index == CSR_ROW0) |=> row_ff[0] == $past(csr_wdata))
      else $error("row 0 write lost");
`endif

endmodule

`default_nettype wire
